// ===== src/bpeg_pkg.sv =====
// Shared types and constants of the breakpoint envelope gain block.
// Used by the divider and the core under src; depends on nothing else.
`default_nettype none

package bpeg_pkg;

  // Envelope table geometry and time range.
  localparam int MaxPoints = 16;
  localparam int TimeBits  = 24;

  // Fixed field widths.
  localparam int PtTimeW   = 24;
  localparam int GainW     = 17;
  localparam int SampleW   = 16;
  localparam int SlotW     = 4;
  localparam int CountW    = 5;
  localparam int StretchW  = 32;

  // Derived widths.
  localparam int AddrW     = $clog2(MaxPoints);
  localparam int IdxW      = AddrW + 1;
  localparam int CntW      = ((IdxW > CountW) ? IdxW : CountW) + 1;
  localparam int TgtW      = PtTimeW + StretchW - 16;
  localparam int AccW      = 40;
  localparam int MultW     = AccW - 16;
  localparam int ProdW     = SampleW + MultW;
  localparam int DiffW     = GainW + 1;
  localparam int DivNumW   = GainW + 16;
  localparam int DivDenW   = TgtW;
  localparam int DivCntW   = $clog2(DivNumW + 1);
  localparam int MulAW     = StretchW + 1;
  localparam int MulBW     = PtTimeW + 1;
  localparam int MulPW     = MulAW + MulBW;

  localparam logic [PtTimeW-1:0] TimeMask =
      PtTimeW'((64'd1 << TimeBits) - 64'd1);

  // Configuration port.
  localparam int CfgAddrW = 3;
  localparam int CfgDataW = 32;
  localparam logic [CountW-1:0]   PointCountRst  = CountW'(1);
  localparam logic [StretchW-1:0] TimeStretchRst = StretchW'(65536);

  typedef enum logic [0:0] {
    REG_POINT_COUNT  = 1'b0,
    REG_TIME_STRETCH = 1'b1
  } reg_idx_e;

  typedef enum logic [0:0] {
    KIND_LOAD   = 1'b0,
    KIND_SAMPLE = 1'b1
  } item_kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_RD_HI,
    ST_RD_LO,
    ST_DIV_SET,
    ST_DIV_WAIT,
    ST_MUL,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic                      kind;
    logic [SlotW-1:0]          point_slot;
    logic [PtTimeW-1:0]        point_time;
    logic [GainW-1:0]          point_gain;
    logic signed [SampleW-1:0] sample_in;
    logic                      buffer_end;
  } in_item_t;

  typedef struct packed {
    logic signed [SampleW-1:0] sample_out;
    logic                      last_out;
    logic                      clipped;
  } out_item_t;

  typedef struct packed {
    logic [PtTimeW-1:0] ptime;
    logic [GainW-1:0]   pgain;
  } pt_entry_t;

endpackage

`default_nettype wire

// ===== src/bpeg_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Stands alone; holds the breakpoint table of the envelope block.
`default_nettype none

module bpeg_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== src/bpeg_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on bpeg_pkg for operand widths; computes the segment slope.
`default_nettype none

module bpeg_div import bpeg_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [DivNumW-1:0] dividend_i,
  input  wire logic [DivDenW-1:0] divisor_i,
  output      logic               done_o,
  output      logic [DivNumW-1:0] quotient_o
);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [DivDenW:0]   rem_q, rem_d;
  logic [DivNumW-1:0] quo_q, quo_d;
  logic [DivDenW-1:0] den_q, den_d;
  logic [DivDenW:0]   trial;
  logic               fits;

  // Shift the next dividend bit into the remainder and try a subtract.
  assign trial = {rem_q[DivDenW-1:0], quo_q[DivNumW-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DivCntW'(DivNumW);
      rem_d  = '0;
      quo_d  = dividend_i;
      den_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = fits ? (trial - {1'b0, den_q}) : trial;
      quo_d = {quo_q[DivNumW-2:0], fits};
      cnt_d = cnt_q - DivCntW'(1);
      if (cnt_q == DivCntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

`ifndef ASSERT_OFF
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider restarted while busy");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("divider done while still busy");
  a_busy_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> cnt_q != '0)
    else $error("divider busy with no steps left");
`endif

endmodule

`default_nettype wire

// ===== src/breakpoint_envelope_gain_core.sv =====
// Breakpoint envelope gain: piecewise linear gain applied to audio samples.
// A sample inside a segment passes the init, multiply and output steps; one at
// a breakpoint crossing also reads two entries and runs the slope divide (33
// steps, one quotient bit per cycle). Loads are taken while idle; no new item
// is taken until a sample leaves the output step, which waits on out_ready_i.
// Reset (rst_ni, async low): sweep state, gain and registers return to defaults.
`default_nettype none

module breakpoint_envelope_gain_core import bpeg_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output      logic                in_ready_o,
  input  wire in_item_t            in_data_i,
  output      logic                out_valid_o,
  input  wire logic                out_ready_i,
  output      out_item_t           out_data_o,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [CfgAddrW-1:0] paddr,
  input  wire logic [CfgDataW-1:0] pwdata,
  output      logic [CfgDataW-1:0] prdata,
  output      logic                pready
);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [CountW-1:0]   point_count_q;
  logic [StretchW-1:0] time_stretch_q;
  reg_idx_e            cfg_idx;
  logic                cfg_write;

  assign pready    = 1'b1;
  assign cfg_idx   = reg_idx_e'(paddr[CfgAddrW-1:2]);
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      point_count_q  <= PointCountRst;
      time_stretch_q <= TimeStretchRst;
    end else if (cfg_write) begin
      case (cfg_idx)
        REG_POINT_COUNT:  point_count_q  <= pwdata[CountW-1:0];
        REG_TIME_STRETCH: time_stretch_q <= pwdata[StretchW-1:0];
        default:          ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_POINT_COUNT:  prdata = CfgDataW'(point_count_q);
      REG_TIME_STRETCH: prdata = CfgDataW'(time_stretch_q);
      default:          prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------
  state_e                    state_q, state_d;
  logic [IdxW-1:0]           tidx_q, tidx_d;
  logic [TgtW-1:0]           tgt_q, tgt_d;
  logic [TgtW-1:0]           old_tgt_q, old_tgt_d;
  logic signed [AccW-1:0]    slope_q, slope_d;
  logic signed [AccW-1:0]    acc_q, acc_d;
  logic [TimeBits-1:0]       sidx_q, sidx_d;
  logic                      done_q, done_d;
  logic                      out_valid_q, out_valid_d;
  out_item_t                 out_q, out_d;

  // Payload registers, no reset needed.
  logic signed [SampleW-1:0] smp_q;
  logic                      last_q;
  logic [PtTimeW-1:0]        ptime_q;
  logic [GainW-1:0]          ghi_q;
  logic signed [DiffW-1:0]   diff_q;
  logic signed [ProdW-1:0]   prod_q;

  // Control outputs of the sequencer.
  logic                      in_xfer;
  logic                      out_free;
  logic                      div_start;
  logic [AddrW-1:0]          raddr;

  assign in_xfer  = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  // ---------------------------------------------------------------------
  // Breakpoint table: a load writes it in the transfer cycle.
  // ---------------------------------------------------------------------
  logic      tbl_we;
  pt_entry_t tbl_wdata;
  pt_entry_t tbl_rdata;
  logic [$bits(pt_entry_t)-1:0] tbl_rbits;

  assign tbl_we = in_xfer && (in_data_i.kind == KIND_LOAD)
               && (CntW'(in_data_i.point_slot) < CntW'(MaxPoints));
  assign tbl_wdata.ptime = in_data_i.point_time & TimeMask;
  assign tbl_wdata.pgain = in_data_i.point_gain;
  assign tbl_rdata       = pt_entry_t'(tbl_rbits);

  bpeg_ram #(
    .Width ($bits(pt_entry_t)),
    .Depth (MaxPoints)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (AddrW'(in_data_i.point_slot)),
    .wdata_i (tbl_wdata),
    .raddr_i (raddr),
    .rdata_o (tbl_rbits)
  );

  // ---------------------------------------------------------------------
  // Breakpoint decision
  // ---------------------------------------------------------------------
  logic [CntW-1:0] pc_ext, act_cnt, tidx_inc;
  logic            at_target, env_end;

  assign pc_ext   = CntW'(point_count_q);
  assign act_cnt  = (pc_ext == '0) ? CntW'(1)
                  : (pc_ext > CntW'(MaxPoints)) ? CntW'(MaxPoints) : pc_ext;
  assign tidx_inc = CntW'(tidx_q) + CntW'(1);
  assign at_target = !done_q && (tgt_q <= TgtW'(sidx_q));
  assign env_end  = (tidx_inc >= act_cnt) || (tidx_inc >= CntW'(MaxPoints));

  // ---------------------------------------------------------------------
  // Shared multiplier: stretch times breakpoint time, or sample times gain.
  // ---------------------------------------------------------------------
  logic signed [MultW-1:0] mult_s;
  logic signed [MulAW-1:0] mul_a;
  logic signed [MulBW-1:0] mul_b;
  logic signed [MulPW-1:0] mul_p;

  assign mult_s = acc_q[AccW-1:16];

  always_comb begin
    if (state_q == ST_RD_LO) begin
      mul_a = signed'({1'b0, time_stretch_q});
      mul_b = signed'({1'b0, ptime_q});
    end else begin
      mul_a = MulAW'(mult_s);
      mul_b = MulBW'(smp_q);
    end
  end

  assign mul_p = mul_a * mul_b;

  // ---------------------------------------------------------------------
  // Slope divider
  // ---------------------------------------------------------------------
  logic [TgtW:0]        per_raw;
  logic [DivDenW-1:0]   period;
  logic [DiffW-1:0]     diff_mag;
  logic [DivNumW-1:0]   div_num;
  logic                 div_done;
  logic [DivNumW-1:0]   div_quo;

  // Non-increasing targets give a period of one.
  assign per_raw  = {1'b0, tgt_q} - {1'b0, old_tgt_q};
  assign period   = (per_raw[TgtW] || per_raw == '0) ? DivDenW'(1) : per_raw[TgtW-1:0];
  assign diff_mag = diff_q[DiffW-1] ? DiffW'(-diff_q) : DiffW'(diff_q);
  assign div_num  = {diff_mag[GainW-1:0], 16'b0};

  bpeg_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  (period),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // ---------------------------------------------------------------------
  // Output rounding, saturation, and gain ramp
  // ---------------------------------------------------------------------
  logic signed [ProdW:0]   rnd_sum;
  logic signed [ProdW-16:0] rnd;
  logic                    sat_hi, sat_lo;
  logic signed [AccW:0]    acc_sum;
  logic signed [AccW-1:0]  acc_next;

  assign rnd_sum = (ProdW+1)'(prod_q) + (ProdW+1)'(32768);
  assign rnd     = rnd_sum[ProdW:16];
  assign sat_hi  = rnd > (ProdW-15)'(32767);
  assign sat_lo  = rnd < -(ProdW-15)'(32768);

  assign acc_sum = (AccW+1)'(acc_q) + (AccW+1)'(slope_q);
  always_comb begin
    if (acc_sum[AccW] != acc_sum[AccW-1]) begin
      acc_next = acc_sum[AccW] ? {1'b1, {(AccW-1){1'b0}}} : {1'b0, {(AccW-1){1'b1}}};
    end else begin
      acc_next = acc_sum[AccW-1:0];
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer && in_data_i.kind == KIND_SAMPLE) begin
          state_d = ST_INIT;
        end
      end
      ST_INIT: begin
        state_d = (at_target && !env_end) ? ST_RD_HI : ST_MUL;
      end
      ST_RD_HI:    state_d = ST_RD_LO;
      ST_RD_LO:    state_d = ST_DIV_SET;
      ST_DIV_SET:  state_d = ST_DIV_WAIT;
      ST_DIV_WAIT: state_d = div_done ? ST_MUL : ST_DIV_WAIT;
      ST_MUL:      state_d = ST_OUT;
      ST_OUT:      state_d = out_free ? ST_IDLE : ST_OUT;
      default:     state_d = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------
  // Sequencer: outputs
  // ---------------------------------------------------------------------
  always_comb begin
    in_ready_o = 1'b0;
    div_start  = 1'b0;
    raddr      = '0;
    case (state_q)
      // Keep entry 0 on the read port so the sweep start has it next cycle.
      ST_IDLE:    in_ready_o = 1'b1;
      ST_INIT:    raddr      = tidx_inc[AddrW-1:0];
      ST_RD_HI:   raddr      = AddrW'(tidx_q - IdxW'(1));
      ST_DIV_SET: div_start  = 1'b1;
      default:    ;
    endcase
  end

  // ---------------------------------------------------------------------
  // Datapath next values
  // ---------------------------------------------------------------------
  always_comb begin
    tidx_d      = tidx_q;
    tgt_d       = tgt_q;
    old_tgt_d   = old_tgt_q;
    slope_d     = slope_q;
    acc_d       = acc_q;
    sidx_d      = sidx_q;
    done_d      = done_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    case (state_q)
      ST_INIT: begin
        // Load the starting gain at the first sample of a sweep.
        if (sidx_q == '0) begin
          acc_d = AccW'({tbl_rdata.pgain, 16'b0});
        end
        if (at_target) begin
          if (env_end) begin
            done_d  = 1'b1;
            slope_d = '0;
          end else begin
            tidx_d    = tidx_inc[IdxW-1:0];
            old_tgt_d = tgt_q;
          end
        end
      end
      ST_RD_LO: begin
        tgt_d = mul_p[TgtW+15:16];
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          slope_d = diff_q[DiffW-1] ? -AccW'(div_quo) : AccW'(div_quo);
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_d        = 1'b1;
          out_d.sample_out   = sat_hi ? SampleW'(32767)
                             : sat_lo ? SampleW'(-32768) : rnd[SampleW-1:0];
          out_d.clipped      = sat_hi || sat_lo;
          out_d.last_out     = last_q;
          acc_d              = acc_next;
          if (sidx_q != '1) begin
            sidx_d = sidx_q + TimeBits'(1);
          end
          // Restart the sweep after the last sample of a buffer.
          if (last_q) begin
            sidx_d  = '0;
            tidx_d  = '0;
            tgt_d   = '0;
            slope_d = '0;
            done_d  = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      tidx_q      <= '0;
      tgt_q       <= '0;
      old_tgt_q   <= '0;
      slope_q     <= '0;
      acc_q       <= '0;
      sidx_q      <= '0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      tidx_q      <= tidx_d;
      tgt_q       <= tgt_d;
      old_tgt_q   <= old_tgt_d;
      slope_q     <= slope_d;
      acc_q       <= acc_d;
      sidx_q      <= sidx_d;
      done_q      <= done_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (in_xfer) begin
      smp_q  <= in_data_i.sample_in;
      last_q <= in_data_i.buffer_end;
    end
    if (state_q == ST_RD_HI) begin
      ptime_q <= tbl_rdata.ptime;
      ghi_q   <= tbl_rdata.pgain;
    end
    if (state_q == ST_RD_LO) begin
      diff_q <= signed'({1'b0, ghi_q}) - signed'({1'b0, tbl_rdata.pgain});
    end
    if (state_q == ST_MUL) begin
      prod_q <= mul_p[ProdW-1:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef ASSERT_OFF
  a_done_flat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> slope_q == '0)
    else $error("gain still ramps after the last breakpoint");
  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CntW'(tidx_q) < CntW'(MaxPoints))
    else $error("breakpoint index out of range");
  a_sample_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && in_data_i.kind == KIND_SAMPLE |=> state_q == ST_INIT)
    else $error("sample transfer did not start the sequence");
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_OUT))
    else $error("result raised outside the output step");
`endif

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking testbench for breakpoint_envelope_gain_core.
// Depends on bpeg_pkg and the core under src; predicts every scaled sample in-line.
`timescale 1ns / 1ps

module tb_top;
  import bpeg_pkg::*;

  // Stimulus sizing.
  localparam int unsigned ItemTarget  = 1550;
  localparam int unsigned GapMax      = 6;
  // Covers the slowest sample, one at a breakpoint crossing, with margin.
  localparam int unsigned DrainCycles = 48;
  localparam int unsigned SweepCap    = 96;
  localparam int unsigned ReportMax   = 10;

  localparam longint AccMax = 64'sd549755813887;
  localparam longint AccMin = -AccMax - 1;

  // One directed row: a transfer plus, where obvious, its expected result.
  typedef struct packed {
    item_kind_e                kind;
    logic [SlotW-1:0]          slot;
    logic [PtTimeW-1:0]        ptime;
    logic [GainW-1:0]          pgain;
    logic signed [SampleW-1:0] smp;
    logic                      last;
    logic                      pinned;
    logic signed [SampleW-1:0] want_smp;
    logic                      want_clip;
  } dir_row_t;

  // Runs under reset settings: one breakpoint, unit stretch.
  localparam int unsigned DirRows = 22;
  localparam dir_row_t DirTab [DirRows] = '{
    // unity gain: extremes pass straight through
    '{KIND_LOAD,   4'd0,  24'hFFFFFF, 17'h10000, 16'sh0000, 1'b0, 1'b0, 16'sh0000, 1'b0},
    '{KIND_SAMPLE, 4'd0,  24'd0,      17'd0,     16'sh7FFF, 1'b1, 1'b1, 16'sh7FFF, 1'b0},
    '{KIND_SAMPLE, 4'd0,  24'd0,      17'd0,     16'sh8000, 1'b1, 1'b1, 16'sh8000, 1'b0},
    '{KIND_SAMPLE, 4'd0,  24'd0,      17'd0,     16'sh0000, 1'b1, 1'b1, 16'sh0000, 1'b0},
    // largest gain: both rails clip
    '{KIND_LOAD,   4'd0,  24'd0,      17'h1FFFF, 16'sh0000, 1'b0, 1'b0, 16'sh0000, 1'b0},
    '{KIND_SAMPLE, 4'd0,  24'd0,      17'd0,     16'sh7FFF, 1'b1, 1'b1, 16'sh7FFF, 1'b1},
    '{KIND_SAMPLE, 4'd0,  24'd0,      17'd0,     16'sh8000, 1'b1, 1'b1, 16'sh8000, 1'b1},
    '{KIND_SAMPLE, 4'd0,  24'd0,      17'd0,     16'sh0001, 1'b1, 1'b0, 16'sh0000, 1'b0},
    '{KIND_SAMPLE, 4'd0,  24'd0,      17'd0,     16'shFFFF, 1'b1, 1'b0, 16'sh0000, 1'b0},
    // zero gain: everything mutes, within and across a sweep
    '{KIND_LOAD,   4'd0,  24'd0,      17'd0,     16'sh0000, 1'b0, 1'b0, 16'sh0000, 1'b0},
    '{KIND_SAMPLE, 4'd0,  24'd0,      17'd0,     16'sh8000, 1'b0, 1'b1, 16'sh0000, 1'b0},
    '{KIND_SAMPLE, 4'd0,  24'd0,      17'd0,     16'sh7FFF, 1'b1, 1'b1, 16'sh0000, 1'b0},
    // half gain: rounding of odd values in both signs
    '{KIND_LOAD,   4'd0,  24'd0,      17'h08000, 16'sh0000, 1'b0, 1'b0, 16'sh0000, 1'b0},
    '{KIND_SAMPLE, 4'd0,  24'd0,      17'd0,     16'sh0003, 1'b1, 1'b0, 16'sh0000, 1'b0},
    '{KIND_SAMPLE, 4'd0,  24'd0,      17'd0,     16'shFFFD, 1'b1, 1'b0, 16'sh0000, 1'b0},
    // top slot and an unused slot; neither affects a one-point envelope
    '{KIND_LOAD,   4'd15, 24'hFFFFFF, 17'h1FFFF, 16'sh0000, 1'b0, 1'b0, 16'sh0000, 1'b0},
    '{KIND_LOAD,   4'd1,  24'd0,      17'd0,     16'sh0000, 1'b0, 1'b0, 16'sh0000, 1'b0},
    // a load in mid-sweep must not disturb the running gain
    '{KIND_SAMPLE, 4'd0,  24'd0,      17'd0,     16'sh3039, 1'b0, 1'b0, 16'sh0000, 1'b0},
    '{KIND_LOAD,   4'd0,  24'd0,      17'h10000, 16'sh0000, 1'b0, 1'b0, 16'sh0000, 1'b0},
    '{KIND_SAMPLE, 4'd0,  24'd0,      17'd0,     16'sh0064, 1'b0, 1'b0, 16'sh0000, 1'b0},
    '{KIND_SAMPLE, 4'd0,  24'd0,      17'd0,     16'sh0064, 1'b1, 1'b0, 16'sh0000, 1'b0},
    '{KIND_SAMPLE, 4'd0,  24'd0,      17'd0,     16'sh0064, 1'b1, 1'b0, 16'sh0000, 1'b0}
  };

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  in_item_t            in_data_i   = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  out_item_t           out_data_o;
  logic                psel        = 1'b0;
  logic                penable     = 1'b0;
  logic                pwrite      = 1'b0;
  logic [CfgAddrW-1:0] paddr       = '0;
  logic [CfgDataW-1:0] pwdata      = '0;
  logic [CfgDataW-1:0] prdata;
  logic                pready;

  breakpoint_envelope_gain_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #4 clk_i = ~clk_i;

  // Envelope prediction state: breakpoint table, registers, and sweep.
  logic [PtTimeW-1:0]  bp_time [MaxPoints];
  logic [GainW-1:0]    bp_gain [MaxPoints];
  logic [CountW-1:0]   cfg_count   = PointCountRst;
  logic [StretchW-1:0] cfg_stretch = TimeStretchRst;
  int unsigned         seg_idx     = 0;
  logic [63:0]         seg_end     = '0;
  longint              ramp        = 0;
  longint              gain_acc    = 0;
  logic [63:0]         sweep_pos   = '0;
  bit                  env_held    = 1'b0;

  // Scaled samples still owed by the block, oldest first.
  out_item_t   scaled_samples_q [$];
  out_item_t   want;
  int unsigned mismatch_cnt  = 0;
  int unsigned results_seen  = 0;
  int unsigned loads_sent    = 0;
  int unsigned samples_sent  = 0;
  int unsigned settings_cnt  = 0;
  bit          calm_run      = 1'b0;
  int unsigned rx_hold       = 0;
  int unsigned rx_draw;

  // Breakpoints in play: zero acts as one, anything above the table as the table.
  function automatic int unsigned live_points();
    if (cfg_count == 0) return 1;
    if (cfg_count > MaxPoints) return MaxPoints;
    return int'(cfg_count);
  endfunction

  // Advance the envelope by one transfer; produce the scaled sample if any.
  function automatic void apply_envelope(input in_item_t it, output bit produced,
                                         output out_item_t res);
    longint      smp, mult, prod, rnd, nxt, period, diff;
    logic [63:0] seg_start;
    bit          clip;
    produced = 1'b0;
    res      = '0;
    clip     = 1'b0;
    if (it.kind == KIND_LOAD) begin
      bp_time[it.point_slot] = it.point_time & TimeMask;
      bp_gain[it.point_slot] = it.point_gain;
      return;
    end
    // Sweep start: reload the gain from breakpoint zero.
    if (sweep_pos == 0) gain_acc = longint'(bp_gain[0]) * 65536;
    // Target reached: step to the next breakpoint, or hold once out of points.
    if (!env_held && seg_end <= sweep_pos) begin
      if (seg_idx + 1 >= live_points() || seg_idx + 1 >= MaxPoints) begin
        env_held = 1'b1;
        ramp     = 0;
      end else begin
        seg_start = seg_end;
        seg_idx++;
        seg_end = (64'(bp_time[seg_idx]) * 64'(cfg_stretch)) >> 16;
        period  = longint'(seg_end) - longint'(seg_start);
        if (period < 1) period = 1;
        diff = longint'(bp_gain[seg_idx]) - longint'(bp_gain[seg_idx - 1]);
        ramp = (diff * 65536) / period;
      end
    end
    smp  = longint'($signed(it.sample_in));
    mult = gain_acc >>> 16;
    prod = smp * mult;
    rnd  = (prod + 32768) >>> 16;
    if (rnd > 32767) begin
      rnd  = 32767;
      clip = 1'b1;
    end else if (rnd < -32768) begin
      rnd  = -32768;
      clip = 1'b1;
    end
    nxt = gain_acc + ramp;
    if (nxt > AccMax) nxt = AccMax;
    else if (nxt < AccMin) nxt = AccMin;
    gain_acc = nxt;
    // Long sweeps stick at the top of the time range.
    if (sweep_pos < 64'(TimeMask)) sweep_pos++;
    res.sample_out = SampleW'(rnd);
    res.last_out   = it.buffer_end;
    res.clipped    = clip;
    produced       = 1'b1;
    if (it.buffer_end) begin
      sweep_pos = '0;
      seg_idx   = 0;
      seg_end   = '0;
      ramp      = 0;
      env_held  = 1'b0;
    end
  endfunction

  function automatic in_item_t rand_item();
    return in_item_t'($bits(in_item_t)'({$urandom(), $urandom()}));
  endfunction

  // Present one item after a random gap, hold it until the transfer, then predict.
  task automatic send_item(input in_item_t it, input bit pinned, input out_item_t pin);
    int unsigned gap;
    bit          produced;
    out_item_t   res;
    gap = calm_run ? 0 : $urandom_range(0, GapMax);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    apply_envelope(it, produced, res);
    if (produced) begin
      scaled_samples_q.push_back(pinned ? pin : res);
      samples_sent++;
    end else begin
      loads_sent++;
    end
  endtask

  // Drop valid, wait for every owed result, then let a breakpoint load finish.
  task automatic settle_pipeline();
    in_valid_i <= 1'b0;
    while (scaled_samples_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Setup cycle, then access cycle; the register takes the data at the access edge.
  task automatic cfg_write(input reg_idx_e idx, input logic [CfgDataW-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CfgAddrW'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      REG_POINT_COUNT:  cfg_count   = val[CountW-1:0];
      REG_TIME_STRETCH: cfg_stretch = val[StretchW-1:0];
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  // Build one envelope of well-formed breakpoints, then sweep through it.
  task automatic run_envelope_phase();
    int unsigned pts, nsmp, t;
    logic [63:0] span;
    in_item_t    it;
    pts = live_points();
    t   = 0;
    for (int k = 0; k < pts; k++) begin
      // Mostly rising times; now and then step back to force a one-sample period.
      if (k > 0 && $urandom_range(0, 7) == 0) t = (t >= 3) ? t - $urandom_range(0, 3) : 0;
      else t = t + $urandom_range(0, 5);
      it            = rand_item();
      it.kind       = KIND_LOAD;
      it.point_slot = SlotW'(k);
      it.point_time = PtTimeW'(t);
      case ($urandom_range(0, 9))
        0:       it.point_gain = '0;
        1:       it.point_gain = '1;
        2:       it.point_gain = 17'h10000;
        default: ;
      endcase
      send_item(it, 1'b0, '0);
    end
    span = (64'(t) * 64'(cfg_stretch)) >> 16;
    nsmp = (span >= SweepCap) ? SweepCap : int'(span[31:0]) + $urandom_range(1, 12);
    for (int j = 0; j < nsmp; j++) begin
      // Noise: a stray load of random content lands in the running sweep.
      if ($urandom_range(0, 23) == 0) begin
        it      = rand_item();
        it.kind = KIND_LOAD;
        send_item(it, 1'b0, '0);
      end
      it      = rand_item();
      it.kind = KIND_SAMPLE;
      case ($urandom_range(0, 11))
        0:       it.sample_in = 16'sh7FFF;
        1:       it.sample_in = 16'sh8000;
        2:       it.sample_in = '0;
        default: ;
      endcase
      // End most sweeps on the last sample; leave some running into the next phase.
      it.buffer_end = (j == nsmp - 1) ? ($urandom_range(0, 3) != 0)
                                      : ($urandom_range(0, 63) == 0);
      send_item(it, 1'b0, '0);
    end
  endtask

  // Receiver: stall a random number of cycles after each transfer.
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      rx_draw = calm_run ? 0 : $urandom_range(0, GapMax);
      out_ready_i <= (rx_draw == 0);
      rx_hold     <= rx_draw;
    end else if (rx_hold != 0) begin
      rx_hold     <= rx_hold - 1;
      out_ready_i <= (rx_hold == 1);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Compare each scaled sample against the oldest owed one.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (scaled_samples_q.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= ReportMax)
          $display("%0t: unexpected result: sample %0d last %0b clip %0b", $realtime,
                   $signed(out_data_o.sample_out), out_data_o.last_out, out_data_o.clipped);
      end else begin
        want = scaled_samples_q.pop_front();
        results_seen++;
        if (out_data_o.sample_out !== want.sample_out || out_data_o.last_out !== want.last_out ||
            out_data_o.clipped !== want.clipped) begin
          mismatch_cnt++;
          if (mismatch_cnt <= ReportMax)
            $display("%0t: result %0d: expected sample %0d last %0b clip %0b, got %0d %0b %0b",
                     $realtime, results_seen, $signed(want.sample_out), want.last_out,
                     want.clipped, $signed(out_data_o.sample_out), out_data_o.last_out,
                     out_data_o.clipped);
        end
      end
    end
  end

  // Watchdog: fail a run that does not finish in time.
  initial begin
    #4_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    in_item_t            it;
    out_item_t           pin;
    int unsigned         phase_no;
    logic [CountW-1:0]   new_count;
    logic [StretchW-1:0] new_stretch;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Fill every slot first so no sweep ever reads an empty breakpoint.
    for (int s = 0; s < MaxPoints; s++) begin
      it            = rand_item();
      it.kind       = KIND_LOAD;
      it.point_slot = SlotW'(s);
      send_item(it, 1'b0, '0);
    end

    // Directed rows under reset settings.
    for (int r = 0; r < DirRows; r++) begin
      it             = '0;
      it.kind        = DirTab[r].kind;
      it.point_slot  = DirTab[r].slot;
      it.point_time  = DirTab[r].ptime;
      it.point_gain  = DirTab[r].pgain;
      it.sample_in   = DirTab[r].smp;
      it.buffer_end  = DirTab[r].last;
      pin.sample_out = DirTab[r].want_smp;
      pin.last_out   = DirTab[r].last;
      pin.clipped    = DirTab[r].want_clip;
      send_item(it, DirTab[r].pinned, pin);
    end

    // Random phases; registers change only with the block drained.
    phase_no = 0;
    while (loads_sent + samples_sent < ItemTarget) begin
      case (phase_no)
        0: begin new_count = 5'd16; new_stretch = 32'd65536;    end
        1: begin new_count = 5'd1;  new_stretch = 32'd1;        end
        2: begin new_count = 5'd16; new_stretch = 32'hFFFFFFFF; end
        3: begin new_count = 5'd0;  new_stretch = 32'd32768;    end
        4: begin new_count = 5'd31; new_stretch = 32'd131072;   end
        default: begin
          new_count = ($urandom_range(0, 7) == 0) ? CountW'($urandom_range(0, 31))
                                                  : CountW'($urandom_range(2, 16));
          case ($urandom_range(0, 7))
            0:       new_stretch = 32'd1;
            1:       new_stretch = 32'hFFFFFFFF;
            default: new_stretch = StretchW'($urandom_range(16384, 131072));
          endcase
        end
      endcase
      settle_pipeline();
      cfg_write(REG_POINT_COUNT, CfgDataW'(new_count));
      cfg_write(REG_TIME_STRETCH, new_stretch);
      settings_cnt++;
      calm_run = ($urandom_range(0, 3) == 0);
      run_envelope_phase();
      phase_no++;
    end

    settle_pipeline();
    $display("Sent %0d samples and %0d breakpoint loads over %0d register settings.",
             samples_sent, loads_sent, settings_cnt);
    $display("Checked %0d results: %0d mismatches, %0d still owed.",
             results_seen, mismatch_cnt, scaled_samples_q.size());
    if (mismatch_cnt == 0 && scaled_samples_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
